// File: rtl/core/sht_pkg.sv
// Shared types and constants for the sparse histogram table.
package sht_pkg;
  localparam int ENTRIES = 256;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0, OP_ADD = 3'd1, OP_SET = 3'd2, OP_APPEND = 3'd3,
    OP_ZERO = 3'd4, OP_SORT_CAT = 3'd5, OP_SORT_CNT = 3'd6, OP_READ = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_RANGE = 2'd2
  } status_t;

  // datapath commands
  typedef enum logic [3:0] {
    DC_NONE, DC_LATCH, DC_CLEAR, DC_RD_A, DC_RD_B, DC_WR_HIT, DC_APPEND, DC_ZERO,
    DC_WR_A, DC_WR_B, DC_MERGE_INIT, DC_MERGE, DC_MERGE_END, DC_READ
  } dcmd_t;

  typedef struct packed {
    dcmd_t           cmd;
    logic [IDX_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] used;
    logic             hit;
    logic             less;
  } stat_t;
endpackage

// File: rtl/core/sht_datapath.sv
// Datapath: entry memories, operand latches and compare logic.
module sht_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sht_pkg::cmd_t        cmd,
  input  logic [2:0]           op_i,
  input  logic [31:0]          cat_i,
  input  logic [63:0]          cnt_i,
  output sht_pkg::stat_t       stat,
  output logic [31:0]          cat_o,
  output logic [63:0]          cnt_o
);
  import sht_pkg::*;
  logic [31:0] cat_mem [ENTRIES];
  logic [63:0] cnt_mem [ENTRIES];
  logic [31:0] rcat, ca_r, cb_r, kcat_r;
  logic [63:0] rcnt, ka_r, kb_r, kcnt_r;
  logic [2:0]  op_r;
  logic [CNT_W-1:0] used_r, used_nxt, ma_r;
  logic [IDX_W-1:0] addr_r;
  logic less;
  logic wr_en;
  logic [IDX_W-1:0] wr_a;
  logic [31:0] wr_c;
  logic [63:0] wr_k;

  always_ff @(posedge clk) begin
    rcat <= cat_mem[cmd.addr];
    rcnt <= cnt_mem[cmd.addr];
    if (wr_en) begin
      cat_mem[wr_a] <= wr_c;
      cnt_mem[wr_a] <= wr_k;
    end
  end

  // b holds the upper entry, a the one below it
  always_comb begin
    if (op_r == OP_SORT_CNT && ka_r != kb_r)
      less = $signed(kb_r) < $signed(ka_r);
    else
      less = $signed(cb_r) < $signed(ca_r);
  end

  always_comb begin
    wr_en = 1'b0; wr_a = cmd.addr; wr_c = rcat; wr_k = rcnt;
    used_nxt = used_r;
    unique case (cmd.cmd)
      DC_CLEAR: used_nxt = '0;
      DC_WR_HIT: begin
        wr_en = 1'b1; wr_a = cmd.addr; wr_c = kcat_r;
        wr_k = (op_r == OP_SET) ? kcnt_r : ka_r + kcnt_r;
      end
      DC_APPEND: begin
        wr_en = 1'b1; wr_a = used_r[IDX_W-1:0]; wr_c = kcat_r; wr_k = kcnt_r;
        used_nxt = used_r + 1'b1;
      end
      DC_ZERO: begin
        wr_en = 1'b1; wr_c = rcat; wr_k = '0; wr_a = addr_r;
      end
      DC_WR_A: begin
        wr_en = 1'b1; wr_a = cmd.addr; wr_c = ca_r; wr_k = ka_r;
      end
      DC_WR_B: begin
        wr_en = 1'b1; wr_a = cmd.addr; wr_c = cb_r; wr_k = kb_r;
      end
      DC_MERGE: begin
        wr_en = 1'b1; wr_a = ma_r[IDX_W-1:0];
        if (rcat != ca_r) begin
          wr_a = ma_r[IDX_W-1:0] + 1'b1; wr_c = rcat; wr_k = rcnt;
        end else begin
          wr_c = ca_r; wr_k = ka_r + rcnt;
        end
      end
      DC_MERGE_END: used_nxt = ma_r + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) used_r <= '0;
    else used_r <= used_nxt;
    addr_r <= cmd.addr;
    unique case (cmd.cmd)
      DC_LATCH: begin op_r <= op_i; kcat_r <= cat_i; kcnt_r <= cnt_i; end
      DC_RD_A: begin ca_r <= rcat; ka_r <= rcnt; end
      DC_RD_B: begin cb_r <= rcat; kb_r <= rcnt; end
      DC_MERGE_INIT: begin ma_r <= '0; ca_r <= rcat; ka_r <= rcnt; end
      DC_MERGE: begin
        if (rcat != ca_r) begin
          ma_r <= ma_r + 1'b1; ca_r <= rcat; ka_r <= rcnt;
        end else ka_r <= ka_r + rcnt;
      end
      DC_READ: begin cat_o <= rcat; cnt_o <= rcnt; end
      default: ;
    endcase
  end

  assign stat.used = used_r;
  assign stat.hit  = (rcat == kcat_r);
  assign stat.less = less;
endmodule

// File: rtl/core/sht_ctrl.sv
// Controller: sequences clear, append, search, zero, sort, merge and read over the entry memories.
module sht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          op_i,
  input  logic [7:0]          idx_i,
  output logic                out_valid,
  input  logic                out_ready,
  output sht_pkg::status_t    status_o,
  output logic                rd_zero,
  output sht_pkg::cmd_t       cmd,
  input  sht_pkg::stat_t      stat
);
  import sht_pkg::*;
  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001, S_DISP = 15'b000000000000010,
    S_SRCH  = 15'b000000000000100, S_HIT  = 15'b000000000001000,
    S_ZERO  = 15'b000000000010000, S_SI   = 15'b000000000100000,
    S_SB    = 15'b000000001000000, S_SA   = 15'b000000010000000,
    S_SCMP  = 15'b000000100000000, S_SSW  = 15'b000001000000000,
    S_SRA   = 15'b000010000000000, S_MINIT = 15'b000100000000000,
    S_MRG   = 15'b001000000000000, S_RD   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;
  state_t state_r, state_nxt;
  logic [2:0] op_r;
  logic [7:0] idx_r;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  status_t st_r, st_nxt;
  logic rz_r, rz_nxt;

  assign in_ready  = (state_r == S_IDLE) || (state_r == S_OUT && out_ready);
  assign out_valid = (state_r == S_OUT);
  assign status_o  = st_r;
  assign rd_zero   = rz_r;

  always_comb begin
    state_nxt = state_r; i_nxt = i_r; j_nxt = j_r; st_nxt = st_r; rz_nxt = rz_r;
    cmd.cmd = DC_NONE; cmd.addr = i_r[IDX_W-1:0];
    unique case (state_r)
      S_IDLE, S_OUT: begin
        if (state_r == S_OUT && out_ready) state_nxt = S_IDLE;
        if (in_valid && in_ready) begin
          cmd.cmd = DC_LATCH; cmd.addr = '0; i_nxt = '0; st_nxt = ST_OK;
          rz_nxt = 1'b1; state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.addr = '0;
        unique case (op_t'(op_r))
          OP_CLEAR: begin cmd.cmd = DC_CLEAR; state_nxt = S_OUT; end
          OP_ADD, OP_SET: state_nxt = S_SRCH;
          OP_APPEND: begin
            if (stat.used == CNT_W'(ENTRIES)) st_nxt = ST_FULL;
            else cmd.cmd = DC_APPEND;
            state_nxt = S_OUT;
          end
          OP_ZERO: state_nxt = S_ZERO;
          OP_SORT_CAT, OP_SORT_CNT: begin i_nxt = CNT_W'(1); state_nxt = S_SI; end
          default: begin
            cmd.addr = idx_r;
            if ({1'b0, idx_r} < stat.used) state_nxt = S_RD;
            else begin st_nxt = ST_RANGE; state_nxt = S_OUT; end
          end
        endcase
      end
      // entry i_r is on the read port
      S_SRCH: begin
        if (i_r >= stat.used) begin
          if (stat.used == CNT_W'(ENTRIES)) st_nxt = ST_FULL;
          else cmd.cmd = DC_APPEND;
          state_nxt = S_OUT;
        end else if (stat.hit) begin
          cmd.cmd = DC_RD_A; state_nxt = S_HIT;
        end else begin
          i_nxt = i_r + 1'b1; cmd.addr = i_r[IDX_W-1:0] + 1'b1;
        end
      end
      S_HIT: begin cmd.cmd = DC_WR_HIT; state_nxt = S_OUT; end
      S_ZERO: begin
        if (i_r >= stat.used) state_nxt = S_OUT;
        else begin
          cmd.cmd = DC_ZERO; i_nxt = i_r + 1'b1; cmd.addr = i_r[IDX_W-1:0] + 1'b1;
        end
      end
      S_SI: begin
        if (i_r >= stat.used) begin
          cmd.addr = '0;
          if (op_r == OP_SORT_CAT && stat.used > CNT_W'(1)) state_nxt = S_MINIT;
          else state_nxt = S_OUT;
        end else begin
          j_nxt = i_r; state_nxt = S_SB;
        end
      end
      S_SB: begin
        cmd.cmd = DC_RD_B; cmd.addr = j_r[IDX_W-1:0] - 1'b1; state_nxt = S_SA;
      end
      S_SA: begin cmd.cmd = DC_RD_A; state_nxt = S_SCMP; end
      S_SCMP: begin
        if (stat.less) begin
          cmd.cmd = DC_WR_A; cmd.addr = j_r[IDX_W-1:0]; state_nxt = S_SSW;
        end else begin
          i_nxt = i_r + 1'b1; state_nxt = S_SI;
        end
      end
      S_SSW: begin
        cmd.cmd = DC_WR_B; cmd.addr = j_r[IDX_W-1:0] - 1'b1;
        if (j_r == CNT_W'(1)) begin i_nxt = i_r + 1'b1; state_nxt = S_SI; end
        else begin j_nxt = j_r - 1'b1; state_nxt = S_SRA; end
      end
      S_SRA: begin cmd.addr = j_r[IDX_W-1:0] - 1'b1; state_nxt = S_SA; end
      S_MINIT: begin
        cmd.cmd = DC_MERGE_INIT; cmd.addr = IDX_W'(1); i_nxt = CNT_W'(1);
        state_nxt = S_MRG;
      end
      S_MRG: begin
        if (i_r >= stat.used) begin
          cmd.cmd = DC_MERGE_END; state_nxt = S_OUT;
        end else begin
          cmd.cmd = DC_MERGE; i_nxt = i_r + 1'b1; cmd.addr = i_r[IDX_W-1:0] + 1'b1;
        end
      end
      S_RD: begin cmd.cmd = DC_READ; rz_nxt = 1'b0; state_nxt = S_OUT; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r <= '0;
      j_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
    end
    st_r <= st_nxt; rz_r <= rz_nxt;
    if (in_valid && in_ready) begin op_r <= op_i; idx_r <= idx_i; end
  end
endmodule

// File: rtl/core/sparse_histogram_table.sv
// Top level of the sparse histogram table.
// Clear, append and an out-of-range read answer from dispatch; a read goes through
// a read state; add/set search the used entries in order, and zero walks them all.
// Sorts: insertion sort on one memory port; category sort merges equal categories.
// One item at a time; the next is taken with the result. Sync reset empties the table.
module sparse_histogram_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [2:0]    in_tuser,  // op
  input  logic [103:0]  in_tdata,  // category_in[31:0], count_in[63:0], read_index[7:0]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [1:0]    out_tuser, // status
  output logic [111:0]  out_tdata  // category_out[31:0], count_out[63:0], entries_used[8:0]
);
  import sht_pkg::*;
  cmd_t  cmd;
  stat_t stat;
  status_t st;
  logic rz;
  logic [31:0] cat_o;
  logic [63:0] cnt_o;

  sht_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .op_i(in_tuser),
    .idx_i(in_tdata[103:96]), .out_valid(out_tvalid), .out_ready(out_tready),
    .status_o(st), .rd_zero(rz), .cmd, .stat
  );

  sht_datapath u_dp (
    .clk, .rst_n, .cmd, .op_i(in_tuser), .cat_i(in_tdata[31:0]),
    .cnt_i(in_tdata[95:32]), .stat, .cat_o, .cnt_o
  );

  assign out_tuser = st;
  assign out_tdata = {7'b0, 9'(stat.used), rz ? 64'd0 : cnt_o, rz ? 32'd0 : cat_o};
endmodule

// File: verif/sparse_histogram_table_tb.sv
// Testbench for the sparse histogram table: directed and random operations checked against a local table model.
module sparse_histogram_table_tb;
  import sht_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] category;
    logic [63:0] count;
    logic [8:0]  used;
  } hist_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [2:0]   in_tuser;
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [1:0]   out_tuser;
  logic [111:0] out_tdata;

  logic [31:0]  tbl_cat [ENTRIES];
  logic [63:0]  tbl_cnt [ENTRIES];
  int           tbl_used;
  hist_result_t pending_results[$];
  int           errors;
  int           send_idle_pct;
  int           recv_idle_pct;
  logic [31:0]  recent_cats[8];

  sparse_histogram_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #400000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit order_before(logic [31:0] ca, logic [63:0] na,
                                      logic [31:0] cb, logic [63:0] nb, bit by_count);
    if (by_count && na != nb)
      return $signed(na) < $signed(nb);
    return $signed(ca) < $signed(cb);
  endfunction

  function automatic void sort_table(bit by_count);
    logic [31:0] c;
    logic [63:0] n;
    for (int i = 1; i < tbl_used; i++) begin
      for (int j = i; j > 0; j--) begin
        if (!order_before(tbl_cat[j], tbl_cnt[j], tbl_cat[j-1], tbl_cnt[j-1], by_count))
          break;
        c = tbl_cat[j]; n = tbl_cnt[j];
        tbl_cat[j] = tbl_cat[j-1]; tbl_cnt[j] = tbl_cnt[j-1];
        tbl_cat[j-1] = c; tbl_cnt[j-1] = n;
      end
    end
  endfunction

  function automatic logic [1:0] append_pair(logic [31:0] cat, logic [63:0] cnt);
    if (tbl_used >= ENTRIES)
      return ST_FULL;
    tbl_cat[tbl_used] = cat;
    tbl_cnt[tbl_used] = cnt;
    tbl_used++;
    return ST_OK;
  endfunction

  function automatic hist_result_t predict_result(op_t op, logic [31:0] cat,
                                                  logic [63:0] cnt, logic [7:0] idx);
    hist_result_t r;
    int a;
    bit found;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_CLEAR: tbl_used = 0;
      OP_ADD, OP_SET: begin
        found = 0;
        for (int i = 0; i < tbl_used && !found; i++) begin
          if (tbl_cat[i] == cat) begin
            tbl_cnt[i] = (op == OP_SET) ? cnt : tbl_cnt[i] + cnt;
            found = 1;
          end
        end
        if (!found)
          r.status = append_pair(cat, cnt);
      end
      OP_APPEND: r.status = append_pair(cat, cnt);
      OP_ZERO: for (int i = 0; i < tbl_used; i++) tbl_cnt[i] = '0;
      OP_SORT_CAT: begin
        sort_table(0);
        if (tbl_used > 1) begin
          a = 0;
          for (int b = 1; b < tbl_used; b++) begin
            if (tbl_cat[a] != tbl_cat[b]) begin
              a++;
              tbl_cat[a] = tbl_cat[b];
              tbl_cnt[a] = tbl_cnt[b];
            end else begin
              tbl_cnt[a] = tbl_cnt[a] + tbl_cnt[b];
            end
          end
          tbl_used = a + 1;
        end
      end
      OP_SORT_CNT: sort_table(1);
      default: begin
        if (idx < tbl_used) begin
          r.category = tbl_cat[idx];
          r.count = tbl_cnt[idx];
        end else begin
          r.status = ST_RANGE;
        end
      end
    endcase
    r.used = tbl_used[8:0];
    return r;
  endfunction

  task automatic send_op(op_t op, logic [31:0] cat = '0, logic [63:0] cnt = '0,
                         logic [7:0] idx = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    pending_results.push_back(predict_result(op, cat, cnt, idx));
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {idx, cnt, cat};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    hist_result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.category = out_tdata[31:0];
        got.count = out_tdata[95:32];
        got.used = out_tdata[104:96];
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.category != want.category) begin
            $display("%0t: category exp %h got %h", $time, want.category, got.category);
            errors++;
          end
          if (got.count != want.count) begin
            $display("%0t: count exp %h got %h", $time, want.count, got.count);
            errors++;
          end
          if (got.used != want.used) begin
            $display("%0t: used exp %0d got %0d", $time, want.used, got.used);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic [31:0] rand_cat();
    case ($urandom_range(3))
      0: return 32'({$urandom, $urandom} >> $urandom_range(31));
      1: return recent_cats[$urandom_range(7)];
      default: return $urandom_range(15) - 8;
    endcase
  endfunction

  function automatic logic [63:0] rand_cnt();
    if ($urandom_range(3) == 0)
      return {$urandom, $urandom};
    return 64'($signed($urandom_range(200)) - 100);
  endfunction

  task automatic test_directed();
    send_op(OP_READ, 0, 0, 8'd0);
    send_op(OP_ADD, 32'h8000_0000, 64'h7fff_ffff_ffff_ffff);
    send_op(OP_ADD, 32'h8000_0000, 64'd1);
    send_op(OP_SET, 32'h7fff_ffff, 64'h8000_0000_0000_0000);
    send_op(OP_APPEND, 32'h7fff_ffff, 64'hffff_ffff_ffff_ffff);
    send_op(OP_APPEND, 32'd0, 64'd5);
    send_op(OP_ADD, 32'hffff_ffff, 64'd3);
    send_op(OP_READ, 0, 0, 8'd0);
    send_op(OP_READ, 0, 0, 8'd1);
    send_op(OP_READ, 0, 0, 8'd5);
    send_op(OP_READ, 0, 0, 8'd255);
    send_op(OP_SORT_CNT);
    for (int i = 0; i < 4; i++) send_op(OP_READ, 0, 0, i[7:0]);
    send_op(OP_SORT_CAT);
    for (int i = 0; i < 4; i++) send_op(OP_READ, 0, 0, i[7:0]);
    send_op(OP_ZERO);
    send_op(OP_READ, 0, 0, 8'd0);
    send_op(OP_CLEAR);
    send_op(OP_READ, 0, 0, 8'd0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < ENTRIES; i++)
      send_op(OP_APPEND, i ^ 32'h0000_0055, {$urandom, $urandom});
    send_op(OP_APPEND, 32'h1234, 64'd1);
    send_op(OP_ADD, 32'h5678, 64'd1);
    send_op(OP_SET, 32'h0000_0055, 64'd9);
    send_op(OP_READ, 0, 0, 8'd255);
    send_op(OP_ZERO);
    send_op(OP_SORT_CNT);
    send_op(OP_READ, 0, 0, 8'd255);
    send_op(OP_CLEAR);
  endtask

  task automatic test_random(int n);
    int k;
    op_t op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 4) op = OP_CLEAR;
      else if (k < 30) op = OP_ADD;
      else if (k < 42) op = OP_SET;
      else if (k < 60) op = OP_APPEND;
      else if (k < 62) op = OP_ZERO;
      else if (k < 65) op = OP_SORT_CAT;
      else if (k < 68) op = OP_SORT_CNT;
      else op = OP_READ;
      if (tbl_used > 40 && op inside {OP_ADD, OP_SET, OP_APPEND})
        op = OP_SORT_CAT;
      recent_cats[$urandom_range(7)] = rand_cat();
      send_op(op, rand_cat(), rand_cnt(),
              8'(($urandom_range(9) == 0) ? $urandom_range(255)
                                          : $urandom_range(tbl_used + 1)));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    tbl_used = 0;
    send_idle_pct = 27;
    recv_idle_pct = 51;
    foreach (recent_cats[i]) recent_cats[i] = i;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_table();
    test_random(350);
    send_idle_pct = 51;
    recv_idle_pct = 27;
    test_random(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(300);
    drain();
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
